// File: rtl/core/bidsc_pkg.sv
// Shared types and constants for the bilinear image downscaler.
// No dependencies; imported by the front end, the back end, the top module and the testbench.
package bidsc_pkg;

  // Fixed field and register widths
  localparam int DIM_W  = 11;  // size registers
  localparam int STEP_W = 27;  // step registers, fixed point
  localparam int COORD_W = 10; // row and column of a result
  localparam int ODD_W  = 12;  // 2d+1 for a destination index
  localparam int PIX_OUT_W = 16;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SRC_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_SRC_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_DST_WIDTH  = 3'd2;
  localparam cfg_idx_t CFG_DST_HEIGHT = 3'd3;
  localparam cfg_idx_t CFG_STEP_X     = 3'd4;
  localparam cfg_idx_t CFG_STEP_Y     = 3'd5;

  // Effective plane geometry, zero read as one and sizes capped
  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } geom_t;

  // Fixed part of one interpolation job handed from front to back
  typedef struct packed {
    logic               r0p;   // parity of top row
    logic               r1p;   // parity of bottom row
    logic [COORD_W-1:0] c0;
    logic [COORD_W-1:0] c1;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               eop;
    logic               last;
  } job_hdr_t;

  // One result item
  typedef struct packed {
    logic [PIX_OUT_W-1:0] pixel;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic                 last;
    logic                 eop;
  } res_t;

endpackage

// File: rtl/core/bidsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bidsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bidsc_fifo.sv
// Small register FIFO used for the job queue and the result queue.
// No dependencies.
module bidsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW:0]      wptr_r;
  logic [PW:0]      rptr_r;

  assign empty = (wptr_r == rptr_r);
  assign full  = (wptr_r[PW] != rptr_r[PW]) && (wptr_r[PW-1:0] == rptr_r[PW-1:0]);
  assign rdata = mem_r[rptr_r[PW-1:0]];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r[PW-1:0]] <= wdata;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (push && !full) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/bidsc_front.sv
// Front end: accepts source pixels, writes the line store, walks the
// destination pixels that each item makes ready and queues jobs. Uses bidsc_pkg.
module bidsc_front #(
  parameter int FRAC_BITS = 16,
  parameter int AW        = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bidsc_pkg::geom_t                      geom,
  input  logic [bidsc_pkg::STEP_W-1:0]          step_x,
  input  logic [bidsc_pkg::STEP_W-1:0]          step_y,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [7:0]                            in_pixel,
  input  logic                                  job_full,
  input  logic                                  job_empty,
  input  logic                                  back_busy,
  output logic                                  job_push,
  output logic [$bits(bidsc_pkg::job_hdr_t)+2*FRAC_BITS+1:0] job_data,
  output logic                                  ram_we,
  output logic [AW:0]                           ram_waddr,
  output logic [7:0]                            ram_wdata
);
  import bidsc_pkg::*;

  localparam int FW = FRAC_BITS + 1;      // position fraction bits
  localparam int PW = ODD_W + STEP_W;     // product width

  typedef enum logic [2:0] {
    S_IDLE, S_MULY, S_MULX, S_NBR, S_CHK, S_FIN
  } state_t;

  state_t           state_r;
  logic [DIM_W-1:0] src_row_r, src_col_r, dst_row_r, dst_col_r;
  logic [DIM_W-1:0] cur_row_r, cur_col_r;
  logic [2:0]       cnt_r;
  logic [PW-1:0]    prod_y_r, prod_x_r;
  logic [COORD_W-1:0] r0_r, r1_r, c0_r, c1_r;
  logic [FW-1:0]    fy_r, fx_r;
  logic             pend_v_r;
  job_hdr_t         pend_hdr_r;
  logic [FW-1:0]    pend_fy_r, pend_fx_r;

  logic [DIM_W-1:0] acc_row_nxt, acc_col_nxt;
  logic             acc_newplane;
  logic             accept;
  logic [ODD_W-1:0] mul_odd;
  logic [STEP_W-1:0] mul_step;
  logic [PW-1:0]    mul_prod;
  logic [PW-1:0]    pos_y, pos_x;
  logic             ready;
  job_hdr_t         new_hdr;
  job_hdr_t         out_hdr;
  logic [DIM_W-1:0] col_inc, row_inc, dcol_inc, drow_inc;

  // Sample position from (2d+1)*step, negative clamped to zero
  function automatic logic [PW-1:0] pos_of(input logic [PW-1:0] prod);
    logic [PW-1:0] half;
    half = PW'(1) << FRAC_BITS;
    return (prod < half) ? '0 : prod - half;
  endfunction

  // Lower neighbor index, clamped to the last row or column
  function automatic logic [COORD_W-1:0] lo_of(input logic [PW-1:0] prod,
                                               input logic [DIM_W-1:0] size);
    logic [PW-1:0] idx;
    logic [PW-1:0] lim;
    idx = pos_of(prod) >> FW;
    lim = PW'(size - 1'b1);
    return (idx > lim) ? COORD_W'(lim) : COORD_W'(idx);
  endfunction

  function automatic logic [COORD_W-1:0] hi_of(input logic [COORD_W-1:0] lo,
                                               input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0] nx;
    nx = DIM_W'(lo) + 1'b1;
    return (nx < size) ? COORD_W'(nx) : COORD_W'(size - 1'b1);
  endfunction

  // Handshake: one item at a time, and never while a job still reads the store
  assign in_full = (state_r != S_IDLE) || !job_empty || back_busy;
  assign accept  = in_push && !in_full;

  // Source position for this item, wrapping if geometry shrank
  always_comb begin
    acc_col_nxt  = src_col_r;
    acc_row_nxt  = src_row_r;
    acc_newplane = 1'b0;
    if (src_col_r >= geom.src_w) begin
      acc_col_nxt = '0;
      acc_row_nxt = src_row_r + 1'b1;
    end
    if (acc_row_nxt >= geom.src_h) begin
      acc_row_nxt  = '0;
      acc_newplane = 1'b1;
    end
  end

  assign ram_we    = accept;
  assign ram_waddr = {acc_row_nxt[0], AW'(acc_col_nxt)};
  assign ram_wdata = in_pixel;

  // Shared position multiplier
  assign mul_odd  = (state_r == S_MULY) ? {dst_row_r, 1'b1} : {dst_col_r, 1'b1};
  assign mul_step = (state_r == S_MULY) ? step_y : step_x;
  assign mul_prod = PW'(mul_odd) * PW'(mul_step);

  // Clamped sample positions for the fraction bits
  assign pos_y = pos_of(prod_y_r);
  assign pos_x = pos_of(prod_x_r);

  // Readiness of the current destination pixel
  assign ready = (cur_row_r > DIM_W'(r1_r)) ||
                 ((cur_row_r == DIM_W'(r1_r)) && (cur_col_r >= DIM_W'(c1_r)));

  always_comb begin
    new_hdr      = '0;
    new_hdr.r0p  = r0_r[0];
    new_hdr.r1p  = r1_r[0];
    new_hdr.c0   = c0_r;
    new_hdr.c1   = c1_r;
    new_hdr.row  = dst_row_r[COORD_W-1:0];
    new_hdr.col  = dst_col_r[COORD_W-1:0];
    new_hdr.eop  = (dst_row_r == geom.dst_h - 1'b1) && (dst_col_r >= geom.dst_w - 1'b1);
    new_hdr.last = 1'b0;
  end

  // Pending job goes out when a later one is ready, or marked last at the end
  always_comb begin
    out_hdr      = pend_hdr_r;
    out_hdr.last = (state_r == S_FIN);
  end
  assign job_push = pend_v_r && !job_full &&
                    ((state_r == S_CHK && ready) || state_r == S_FIN);
  assign job_data = {pend_fy_r, pend_fx_r, out_hdr};

  assign col_inc  = cur_col_r + 1'b1;
  assign row_inc  = cur_row_r + 1'b1;
  assign dcol_inc = dst_col_r + 1'b1;
  assign drow_inc = dst_row_r + 1'b1;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      src_row_r <= '0;
      src_col_r <= '0;
      dst_row_r <= '0;
      dst_col_r <= '0;
      pend_v_r  <= 1'b0;
      cnt_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cur_row_r <= acc_row_nxt;
            cur_col_r <= acc_col_nxt;
            cnt_r     <= '0;
            if (acc_newplane) begin
              dst_row_r <= '0;
              dst_col_r <= '0;
            end
            state_r <= S_MULY;
          end
        end
        S_MULY: begin
          if (cnt_r == 3'd4 || dst_row_r >= geom.dst_h) begin
            state_r <= S_FIN;
          end else begin
            prod_y_r <= mul_prod;
            state_r  <= S_MULX;
          end
        end
        S_MULX: begin
          prod_x_r <= mul_prod;
          state_r  <= S_NBR;
        end
        S_NBR: begin
          r0_r    <= lo_of(prod_y_r, geom.src_h);
          r1_r    <= hi_of(lo_of(prod_y_r, geom.src_h), geom.src_h);
          c0_r    <= lo_of(prod_x_r, geom.src_w);
          c1_r    <= hi_of(lo_of(prod_x_r, geom.src_w), geom.src_w);
          fy_r    <= pos_y[FW-1:0];
          fx_r    <= pos_x[FW-1:0];
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (!ready) begin
            state_r <= S_FIN;
          end else if (!(pend_v_r && job_full)) begin
            pend_v_r   <= 1'b1;
            pend_hdr_r <= new_hdr;
            pend_fy_r  <= fy_r;
            pend_fx_r  <= fx_r;
            cnt_r      <= cnt_r + 1'b1;
            if (dcol_inc >= geom.dst_w) begin
              dst_col_r <= '0;
              dst_row_r <= drow_inc;
            end else begin
              dst_col_r <= dcol_inc;
            end
            state_r <= S_MULY;
          end
        end
        S_FIN: begin
          if (!(pend_v_r && job_full)) begin
            pend_v_r <= 1'b0;
            if (col_inc >= geom.src_w) begin
              src_col_r <= '0;
              if (row_inc >= geom.src_h) begin
                src_row_r <= '0;
                dst_row_r <= '0;
                dst_col_r <= '0;
              end else begin
                src_row_r <= row_inc;
              end
            end else begin
              src_col_r <= col_inc;
              src_row_r <= cur_row_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/bidsc_back.sv
// Back end: takes queued jobs, reads four neighbors from the line store and
// mixes them with one shared multiplier. Uses bidsc_pkg.
module bidsc_back #(
  parameter int FRAC_BITS = 16,
  parameter int AW        = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  job_empty,
  input  logic [$bits(bidsc_pkg::job_hdr_t)+2*FRAC_BITS+1:0] job_data,
  output logic                                  job_pop,
  input  logic                                  res_full,
  output logic                                  res_push,
  output bidsc_pkg::res_t                       res_data,
  output logic [AW:0]                           ram_raddr,
  input  logic [7:0]                            ram_rdata,
  output logic                                  busy
);
  import bidsc_pkg::*;

  localparam int FW  = FRAC_BITS + 1;
  localparam int HW  = $bits(job_hdr_t);
  localparam int TW  = FRAC_BITS + 10;      // one mixed row
  localparam int BW  = FRAC_BITS + 2;       // weight, up to one
  localparam int MW  = TW + BW;             // product
  localparam int VW  = 2 * FRAC_BITS + 11;  // final sum
  localparam int SH  = 2 * FRAC_BITS - 6;   // down to 8 fraction bits

  typedef enum logic [1:0] {B_IDLE, B_RD, B_MAC, B_OUT} state_t;

  state_t        state_r;
  job_hdr_t      hdr_r;
  logic [FW-1:0] fx_r, fy_r;
  logic [2:0]    k_r;
  logic [2:0]    j_r;
  logic [7:0]    px_r [4];
  logic [TW-1:0] t_r, u_r;
  logic [VW-1:0] v_r;

  logic [BW-1:0] one_w, wx0, wy0;
  logic [TW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [MW-1:0] prod;
  logic [VW-1:0] rounded;

  assign busy    = (state_r != B_IDLE);
  assign job_pop = (state_r == B_IDLE) && !job_empty;

  // Neighbor addresses in read order: a, b, c, d
  always_comb begin
    case (k_r[1:0])
      2'd0:    ram_raddr = {hdr_r.r0p, AW'(hdr_r.c0)};
      2'd1:    ram_raddr = {hdr_r.r0p, AW'(hdr_r.c1)};
      2'd2:    ram_raddr = {hdr_r.r1p, AW'(hdr_r.c0)};
      default: ram_raddr = {hdr_r.r1p, AW'(hdr_r.c1)};
    endcase
  end

  // Weights
  assign one_w = BW'(1) << FW;
  assign wx0   = one_w - BW'(fx_r);
  assign wy0   = one_w - BW'(fy_r);

  // Operand select for the shared multiplier
  always_comb begin
    case (j_r)
      3'd0:    begin mul_a = TW'(px_r[0]); mul_b = wx0;       end
      3'd1:    begin mul_a = TW'(px_r[1]); mul_b = BW'(fx_r); end
      3'd2:    begin mul_a = TW'(px_r[2]); mul_b = wx0;       end
      3'd3:    begin mul_a = TW'(px_r[3]); mul_b = BW'(fx_r); end
      3'd4:    begin mul_a = t_r;          mul_b = wy0;       end
      default: begin mul_a = u_r;          mul_b = BW'(fy_r); end
    endcase
  end
  assign prod = MW'(mul_a) * MW'(mul_b);

  // Round half up to 8 fraction bits
  assign rounded = v_r + (VW'(1) << (SH - 1));
  always_comb begin
    res_data       = '0;
    res_data.pixel = rounded[SH +: PIX_OUT_W];
    res_data.row   = hdr_r.row;
    res_data.col   = hdr_r.col;
    res_data.last  = hdr_r.last;
    res_data.eop   = hdr_r.eop;
  end
  assign res_push = (state_r == B_OUT) && !res_full;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (job_pop) begin
            hdr_r   <= job_hdr_t'(job_data[HW-1:0]);
            fx_r    <= job_data[HW +: FW];
            fy_r    <= job_data[HW+FW +: FW];
            k_r     <= '0;
            state_r <= B_RD;
          end
        end
        B_RD: begin
          if (k_r != 3'd0) begin
            px_r[2'(k_r - 3'd1)] <= ram_rdata;
          end
          if (k_r == 3'd4) begin
            j_r     <= '0;
            state_r <= B_MAC;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        B_MAC: begin
          case (j_r)
            3'd0:    t_r <= TW'(prod);
            3'd1:    t_r <= t_r + TW'(prod);
            3'd2:    u_r <= TW'(prod);
            3'd3:    u_r <= u_r + TW'(prod);
            3'd4:    v_r <= VW'(prod);
            default: v_r <= v_r + VW'(prod);
          endcase
          if (j_r == 3'd5) begin
            state_r <= B_OUT;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        B_OUT: begin
          if (!res_full) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/bilinear_image_downscaler.sv
// Bilinear image downscaler, half-pixel centers, one 8-bit source pixel per item.
// An item holds the input until the back unit has computed every result that it makes;
// each result takes four store reads and six multiply steps in the back unit, and a full
// result queue holds the back unit further.
// Reset is synchronous: control and config registers return to defaults, queues empty; store not cleared.
module bilinear_image_downscaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_pixel_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_pixel_out,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        out_last_in_run,
  output logic        out_end_of_plane,
  input  logic        cfg_we,
  input  bidsc_pkg::cfg_idx_t cfg_index,
  input  logic [bidsc_pkg::STEP_W-1:0] cfg_data
);
  import bidsc_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int JW   = $bits(job_hdr_t) + 2 * (FRAC_BITS + 1);
  localparam logic [DIM_W-1:0] WCAP = DIM_W'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
  localparam logic [DIM_W-1:0] DCAP = DIM_W'(1024);

  logic [DIM_W-1:0]  src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [STEP_W-1:0] step_x_r, step_y_r;
  geom_t             geom;

  logic          job_push, job_pop, job_full, job_empty;
  logic [JW-1:0] job_wdata, job_rdata;
  logic          back_busy;
  logic          res_push, res_full;
  res_t          res_wdata, res_rdata;
  logic          ram_we;
  logic [AW:0]   ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v,
                                           input logic [DIM_W-1:0] cap);
    return (v == '0) ? DIM_W'(1) : ((v > cap) ? cap : v);
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(256);
      src_height_r <= DIM_W'(256);
      dst_width_r  <= DIM_W'(128);
      dst_height_r <= DIM_W'(128);
      step_x_r     <= STEP_W'(131072);
      step_y_r     <= STEP_W'(131072);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_data[DIM_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_data[DIM_W-1:0];
        CFG_STEP_X:     step_x_r     <= cfg_data;
        CFG_STEP_Y:     step_y_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  assign geom.src_w = eff(src_width_r, WCAP);
  assign geom.src_h = eff(src_height_r, DCAP);
  assign geom.dst_w = eff(dst_width_r, DCAP);
  assign geom.dst_h = eff(dst_height_r, DCAP);

  // Two-row line store
  bidsc_ram #(.WIDTH(8), .DEPTH(2 ** (AW + 1))) u_line (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  bidsc_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .geom(geom), .step_x(step_x_r), .step_y(step_y_r),
    .in_push(in_push), .in_full(in_full), .in_pixel(in_pixel_in),
    .job_full(job_full), .job_empty(job_empty), .back_busy(back_busy),
    .job_push(job_push), .job_data(job_wdata),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata)
  );

  // Job queue between front and back
  bidsc_fifo #(.WIDTH(JW), .DEPTH(4)) u_jobq (
    .clk(clk), .rst_n(rst_n), .push(job_push), .wdata(job_wdata), .full(job_full),
    .pop(job_pop), .rdata(job_rdata), .empty(job_empty)
  );

  bidsc_back #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n), .job_empty(job_empty), .job_data(job_rdata),
    .job_pop(job_pop), .res_full(res_full), .res_push(res_push),
    .res_data(res_wdata), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
    .busy(back_busy)
  );

  // Result queue
  bidsc_fifo #(.WIDTH($bits(res_t)), .DEPTH(4)) u_resq (
    .clk(clk), .rst_n(rst_n), .push(res_push), .wdata(res_wdata), .full(res_full),
    .pop(out_pop), .rdata(res_rdata), .empty(out_empty)
  );

  assign out_pixel_out    = res_rdata.pixel;
  assign out_row          = res_rdata.row;
  assign out_col          = res_rdata.col;
  assign out_last_in_run  = res_rdata.last;
  assign out_end_of_plane = res_rdata.eop;

  // Checks
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("input not blocked after an accepted item");

  a_no_store_write_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> !ram_we)
    else $error("line store written while a job reads it");

  a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job queue overflow");

  a_resq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

endmodule

// File: sim/bilinear_image_downscaler_tb.sv
// Self-checking testbench for bilinear_image_downscaler: pixel planes in, scored results out.
// Depends on bidsc_pkg and the RTL only; expected pixels come from a built-in predictor.
`timescale 1ns / 1ps

module bilinear_image_downscaler_tb;
  import bidsc_pkg::*;

  localparam int FRAC = 16;
  localparam int STORE_W = 1024;
  localparam int IDLE_LIMIT = 5000;  // cycles with no accepted item and no result taken
  localparam int DRAIN_CYCLES = 64;  // extra wait after the last expected result

  // Predicts downscaled pixels and scores what the block returns
  class downscale_scoreboard;
    logic [7:0] rows [2*STORE_W];
    int unsigned src_row, src_col, dst_row, dst_col;
    logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
    logic [STEP_W-1:0] step_x, step_y;
    res_t pending_px[$];
    int errors;

    function new();
      foreach (rows[i]) rows[i] = 8'd0;
      src_w = 256; src_h = 256; dst_w = 128; dst_h = 128;
      step_x = 131072; step_y = 131072;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [STEP_W-1:0] val);
      case (idx)
        CFG_SRC_WIDTH:  src_w = val[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_h = val[DIM_W-1:0];
        CFG_DST_WIDTH:  dst_w = val[DIM_W-1:0];
        CFG_DST_HEIGHT: dst_h = val[DIM_W-1:0];
        CFG_STEP_X:     step_x = val;
        CFG_STEP_Y:     step_y = val;
        default: ;
      endcase
    endfunction

    function int unsigned eff_size(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      return (v > 1024) ? 1024 : v;
    endfunction

    // sample position, FRAC+1 fraction bits, clamped at zero
    function longint unsigned sample_pos(int unsigned d, logic [STEP_W-1:0] step);
      longint p;
      p = longint'(2 * d + 1) * longint'(step) - (longint'(1) << FRAC);
      return (p < 0) ? 0 : p;
    endfunction

    function int unsigned lo_tap(longint unsigned pos, int unsigned size);
      longint unsigned i;
      i = pos >> (FRAC + 1);
      return (i > size - 1) ? size - 1 : int'(i);
    endfunction

    function int unsigned slot(int unsigned r, int unsigned c);
      return (r % 2) * STORE_W + (c % STORE_W);
    endfunction

    // Accepted pixel: update store and queue up to four destination pixels it completes
    function void note_pixel(logic [7:0] pix);
      int unsigned w, h, dw, dh, r0, r1, c0, c1, n;
      longint unsigned py, px, fy, fx, one, top, bot, v;
      res_t e;
      w = eff_size(src_w); h = eff_size(src_h);
      dw = eff_size(dst_w); dh = eff_size(dst_h);
      one = longint'(1) << (FRAC + 1);
      n = 0;
      if (src_col >= w) begin src_col = 0; src_row++; end
      if (src_row >= h) begin src_row = 0; dst_row = 0; dst_col = 0; end
      rows[slot(src_row, src_col)] = pix;
      while (n < 4 && dst_row < dh) begin
        py = sample_pos(dst_row, step_y);
        px = sample_pos(dst_col, step_x);
        r0 = lo_tap(py, h); r1 = (r0 + 1 < h) ? r0 + 1 : h - 1;
        c0 = lo_tap(px, w); c1 = (c0 + 1 < w) ? c0 + 1 : w - 1;
        if (!(src_row > r1 || (src_row == r1 && src_col >= c1))) break;
        fy = py & (one - 1);
        fx = px & (one - 1);
        top = rows[slot(r0, c0)] * (one - fx) + rows[slot(r0, c1)] * fx;
        bot = rows[slot(r1, c0)] * (one - fx) + rows[slot(r1, c1)] * fx;
        v = top * (one - fy) + bot * fy;
        v = (v + (longint'(1) << 25)) >> 26;
        e.pixel = v[15:0];
        e.row = dst_row[9:0];
        e.col = dst_col[9:0];
        e.last = 1'b0;
        e.eop = (dst_row == dh - 1 && dst_col >= dw - 1);
        pending_px.push_back(e);
        dst_col++;
        if (dst_col >= dw) begin dst_col = 0; dst_row++; end
        n++;
      end
      if (n > 0) pending_px[pending_px.size() - 1].last = 1'b1;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
        if (src_row >= h) begin src_row = 0; dst_row = 0; dst_col = 0; end
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = pending_px.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_push, in_full;
  logic [7:0] in_pixel_in;
  logic out_empty, out_pop;
  logic [15:0] out_pixel_out;
  logic [9:0] out_row, out_col;
  logic out_last_in_run, out_end_of_plane;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [STEP_W-1:0] cfg_data;

  downscale_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_off, all_sent;
  int idle_cycles;

  bilinear_image_downscaler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_pixel_in(in_pixel_in),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_pixel_out(out_pixel_out), .out_row(out_row), .out_col(out_col),
    .out_last_in_run(out_last_in_run), .out_end_of_plane(out_end_of_plane),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random pop, long hold-off on request
  initial begin
    res_t got;
    out_pop <= 1'b0;
    forever begin
      out_pop <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.pixel = out_pixel_out;
        got.row = out_row;
        got.col = out_col;
        got.last = out_last_in_run;
        got.eop = out_end_of_plane;
        sb.check_result(got);
      end
    end
  end

  // Watchdog on progress
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bilinear_image_downscaler_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(logic [7:0] pix);
    in_push <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_full);
    sb.note_pixel(pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [STEP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Wait until the block is idle, then load a whole geometry
  task automatic set_geometry(int sw, int sh, int dw, int dh, int sx, int sy);
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_SRC_WIDTH, STEP_W'(sw));
    write_reg(CFG_SRC_HEIGHT, STEP_W'(sh));
    write_reg(CFG_DST_WIDTH, STEP_W'(dw));
    write_reg(CFG_DST_HEIGHT, STEP_W'(dh));
    write_reg(CFG_STEP_X, STEP_W'(sx));
    write_reg(CFG_STEP_Y, STEP_W'(sy));
  endtask

  task automatic send_plane(int items);
    for (int i = 0; i < items; i++) send_pixel(8'($urandom_range(255)));
  endtask

  initial begin
    int sent, sw, sh, dw, dh;
    sb = new();
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_pixel_in <= 8'd0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SRC_WIDTH;
    cfg_data <= '0;
    hold_off = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 69;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // more than four pixels ready at once; the rest drop at end of plane
    set_geometry(2, 2, 6, 1, 65536, 65536);
    send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
    // all sizes zero, read as one
    set_geometry(0, 0, 0, 0, 65536, 65536);
    send_pixel(8'd255);
    // step below one: negative positions clamp to zero
    set_geometry(2, 2, 2, 1, 32768, 32768);
    send_pixel(8'd255); send_pixel(8'd1); send_pixel(8'd128); send_pixel(8'd254);
    // plain half-size plane with extreme pixel values
    set_geometry(4, 4, 2, 2, 131072, 131072);
    for (int i = 0; i < 16; i++) send_pixel((i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : 8'd170);
    // wide plane at unit step; tall plane at a step of 1024, rows clamped
    set_geometry(64, 1, 64, 1, 65536, 65536);
    send_plane(64);
    set_geometry(1, 64, 1, 1, 65536, 67108864);
    send_plane(64);

    // random planes: hold-off on the first, idle mix changes part way
    sent = 0;
    while (sent < 200) begin
      if (sent < 100) begin
        send_idle_pct = 69; recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (sent == 0) begin
        sw = 8; sh = 6; dw = 4; dh = 3;
      end else begin
        sw = $urandom_range(1, 8);
        sh = $urandom_range(1, 6);
        dw = $urandom_range(1, sw);
        dh = $urandom_range(1, sh);
      end
      set_geometry(sw, sh, dw, dh, (sw << 16) / dw, (sh << 16) / dh);
      if (sent == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      send_plane(sw * sh);
      sent += sw * sh;
    end

    // drain
    in_push <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("bilinear_image_downscaler_tb: done, clean");
    end else begin
      $display("bilinear_image_downscaler_tb: done, errors");
    end
    $finish;
  end

endmodule
